// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the calendar converter.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk_s, off while rstn_s is low.
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk_s, rstn_s, (ante) |-> (cons), msg)

// Next-cycle implication built on the macro above.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk_s, rstn_s, (ante) |=> (cons), msg)

`endif

// ===== rtl/utcal_pkg.sv =====
// Package for the Unix-time-to-calendar converter: field widths, pipeline
// depth, reciprocal constants and the month start table. No dependencies.
package utcal_pkg;

  // Port field widths.
  localparam int EPOCH_W = 32;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  // Number of register stages from request to result.
  localparam int NUM_STG = 15;

  // Time constants.
  localparam logic [17:0] SECS_PER_DAY = 18'd86400;
  localparam logic [5:0]  SIXTY        = 6'd60;

  // Day-count constants of the shifted-era method.
  localparam logic [10:0] DAYS_4Y      = 11'd1460;
  localparam logic [8:0]  DAYS_YR      = 9'd365;
  localparam int          DAYS_100Y    = 36524;
  localparam logic [17:0] DAYS_400Y_M1 = 18'd146096;

  // Days since 1970 of 2000-03-01, where the era starting in 2000 begins.
  localparam logic [15:0] ERA5_DAY     = 16'd11017;
  // Offset from days since 1970 to day of era for the era starting in 1600.
  localparam logic [17:0] ERA4_OFFSET  = 18'd135080;
  localparam logic [11:0] YEAR_ERA4    = 12'd1600;
  localparam logic [11:0] YEAR_ERA5    = 12'd2000;

  // Floor reciprocals: q0 = (x * R) >> K is the quotient or one below it
  // for every x below 2**K, so one compare and subtract finishes it.
  // The day divide first drops the factor 2**7 of 86400, leaving 675.
  localparam logic [15:0] RCP_DAY = 16'((64'd1 << 25) / 675);
  localparam logic [11:0] RCP_MIN = 12'((64'd1 << 17) / 60);
  localparam logic [5:0]  RCP_HR  = 6'((64'd1 << 11) / 60);
  localparam logic [7:0]  RCP_4Y  = 8'((64'd1 << 18) / 1460);
  localparam logic [9:0]  RCP_YR  = 10'((64'd1 << 18) / 365);

  // Months in a March-based year.
  localparam int MONTHS = 12;

  // First day of year of each March-based month, (153 * mp + 2) / 5.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/unix_time_to_calendar_unit.sv =====
// Top level of the Unix-time-to-calendar converter: a 15-stage pipeline.
// Depends on utcal_pkg and assert_macros.svh.
//
//   channel | ports                      | handshake
//   --------+----------------------------+------------------------------
//   in      | in_epoch_seconds           | start high, busy low
//   out     | out_year .. out_unknown_time | out_valid strobe, one cycle
//
// Each request gives one result, and a new request may enter in every
// cycle. The pipeline depth is set by the chain of constant divisions,
// each done as a reciprocal multiply, a back-multiply and a correcting
// subtract in stages of their own.
// Reset clears the valid bits and holds busy high; busy stays high for the
// first cycle after reset and is low after that. The receiver cannot stall,
// so the pipeline never stops.
`include "assert_macros.svh"

module unix_time_to_calendar_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [utcal_pkg::EPOCH_W-1:0]  in_epoch_seconds,
  output logic                           out_valid,
  output logic [utcal_pkg::YEAR_W-1:0]   out_year,
  output logic [utcal_pkg::MONTH_W-1:0]  out_month,
  output logic [utcal_pkg::DAY_W-1:0]    out_day,
  output logic [utcal_pkg::HOUR_W-1:0]   out_hour,
  output logic [utcal_pkg::MIN_W-1:0]    out_minute,
  output logic [utcal_pkg::SEC_W-1:0]    out_second,
  output logic                           out_unknown_time
);
  import utcal_pkg::*;

  // Control.
  logic               busy_r;
  logic [NUM_STG:1]   vld_r;
  logic               in_take;

  // Stages 1 to 3: seconds into days and second of day.
  logic [EPOCH_W-1:0] t_r [1:2];
  logic [40:0]        pd_r, pd_nxt;
  logic [15:0]        q_r, q_nxt;
  logic [31:0]        pq_r, pq_nxt;
  logic [31:0]        rem_day;
  logic               fix_day;
  logic [15:0]        days_r, days_nxt;
  logic [16:0]        sod_r [3:5];
  logic [16:0]        sod_nxt;

  // Carried flags and date values.
  logic               zero_r [1:NUM_STG-1];
  logic               era5_r [4:NUM_STG-1];
  logic               era5_nxt;
  logic [17:0]        doe_r [4:12];
  logic [17:0]        doe_nxt;

  // Time of day.
  logic [28:0]        pm_r, pm_nxt;
  logic [10:0]        qm_r, qm_nxt;
  logic [16:0]        pqm_r, pqm_nxt;
  logic [16:0]        rem_min;
  logic               fix_min;
  logic [10:0]        mn_r [6:8];
  logic [10:0]        mn_nxt;
  logic [SEC_W-1:0]   ss_r [6:NUM_STG-1];
  logic [SEC_W-1:0]   ss_nxt;
  logic [15:0]        ph_r, ph_nxt;
  logic [HOUR_W-1:0]  qh_r, qh_nxt;
  logic [10:0]        pqh_r, pqh_nxt;
  logic [10:0]        rem_hr;
  logic               fix_hr;
  logic [HOUR_W-1:0]  hh_r [9:NUM_STG-1];
  logic [HOUR_W-1:0]  hh_nxt;
  logic [MIN_W-1:0]   mi_r [9:NUM_STG-1];
  logic [MIN_W-1:0]   mi_nxt;

  // Year of era and day of year.
  logic [25:0]        pa_r, pa_nxt;
  logic [2:0]         cent_r [5:7];
  logic [2:0]         cent_nxt;
  logic               last_r [5:7];
  logic               last_nxt;
  logic [7:0]         a0_r, a0_nxt;
  logic [17:0]        pqa_r, pqa_nxt;
  logic [17:0]        rem_a;
  logic [6:0]         a_r, a_nxt;
  logic [17:0]        n_r [8:10];
  logic [17:0]        n_nxt;
  logic [27:0]        py_r, py_nxt;
  logic [8:0]         y0_r, y0_nxt;
  logic [17:0]        pqy_r, pqy_nxt;
  logic [17:0]        rem_y;
  logic [8:0]         yoe_r [11:NUM_STG-1];
  logic [8:0]         yoe_nxt;
  logic [1:0]         c100;
  logic [17:0]        m365_r, m365_nxt;
  logic [6:0]         adj_r, adj_nxt;
  logic [8:0]         doy_r [13:14];
  logic [8:0]         doy_nxt;
  logic [3:0]         mp_r, mp_nxt;

  // Result registers.
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [HOUR_W-1:0]  hour_r;
  logic [MIN_W-1:0]   minute_r;
  logic [SEC_W-1:0]   second_r;
  logic               unk_r;

  assign in_take = start && !busy_r;

  // Stage logic, one section per register stage.
  always_comb begin
    // Stage 1: reciprocal of 675 on the seconds shifted down by seven.
    pd_nxt   = 41'(in_epoch_seconds[EPOCH_W-1:7]) * 41'(RCP_DAY);

    // Stage 2: estimated day count and its multiple of 86400.
    q_nxt    = pd_r[40:25];
    pq_nxt   = 32'(33'(q_nxt) * 33'(SECS_PER_DAY));

    // Stage 3: remainder decides whether the estimate was one short.
    rem_day  = t_r[2] - pq_r;
    fix_day  = rem_day[17:0] >= SECS_PER_DAY;
    days_nxt = q_r + 16'(fix_day);
    sod_nxt  = fix_day ? 17'(rem_day[17:0] - SECS_PER_DAY) : rem_day[16:0];

    // Stage 4: every 32-bit count falls in the era of 1600 or of 2000.
    era5_nxt = days_r >= ERA5_DAY;
    doe_nxt  = era5_nxt ? 18'(days_r - ERA5_DAY) : 18'(days_r) + ERA4_OFFSET;
    pm_nxt   = 29'(sod_r[3]) * 29'(RCP_MIN);

    // Stage 5: century count, last day of era, reciprocal of 1460.
    pa_nxt   = 26'(doe_r[4]) * 26'(RCP_4Y);
    cent_nxt = 3'(doe_r[4] >= 18'(DAYS_100Y))     + 3'(doe_r[4] >= 18'(2 * DAYS_100Y))
             + 3'(doe_r[4] >= 18'(3 * DAYS_100Y)) + 3'(doe_r[4] >= DAYS_400Y_M1);
    last_nxt = doe_r[4] == DAYS_400Y_M1;
    qm_nxt   = pm_r[27:17];
    pqm_nxt  = 17'(qm_nxt) * 17'(SIXTY);

    // Stage 6: four-year estimate and its multiple; minute of day corrected.
    a0_nxt   = pa_r[25:18];
    pqa_nxt  = 18'(a0_nxt) * 18'(DAYS_4Y);
    rem_min  = sod_r[5] - pqm_r;
    fix_min  = rem_min >= 17'(SIXTY);
    mn_nxt   = qm_r + 11'(fix_min);
    ss_nxt   = fix_min ? 6'(rem_min - 17'(SIXTY)) : rem_min[5:0];

    // Stage 7: four-year count corrected; reciprocal of 60 on minute of day.
    rem_a    = doe_r[6] - pqa_r;
    a_nxt    = 7'(a0_r) + 7'(rem_a >= 18'(DAYS_4Y));
    ph_nxt   = 16'(mn_r[6]) * 16'(RCP_HR);

    // Stage 8: leap-adjusted day of era; hour estimate and its multiple.
    n_nxt    = doe_r[7] - 18'(a_r) + 18'(cent_r[7]) - 18'(last_r[7]);
    qh_nxt   = ph_r[15:11];
    pqh_nxt  = 11'(qh_nxt) * 11'(SIXTY);

    // Stage 9: reciprocal of 365; hour and minute corrected.
    py_nxt   = 28'(n_r[8]) * 28'(RCP_YR);
    rem_hr   = mn_r[8] - pqh_r;
    fix_hr   = rem_hr >= 11'(SIXTY);
    hh_nxt   = qh_r + 5'(fix_hr);
    mi_nxt   = fix_hr ? 6'(rem_hr - 11'(SIXTY)) : rem_hr[5:0];

    // Stage 10: year estimate and its multiple of 365.
    y0_nxt   = py_r[26:18];
    pqy_nxt  = 18'(y0_nxt) * 18'(DAYS_YR);

    // Stage 11: year of era corrected.
    rem_y    = n_r[10] - pqy_r;
    yoe_nxt  = y0_r + 9'(rem_y >= 18'(DAYS_YR));

    // Stage 12: days before this year of era, split in product and leap part.
    c100     = 2'(yoe_r[11] >= 9'd100) + 2'(yoe_r[11] >= 9'd200)
             + 2'(yoe_r[11] >= 9'd300);
    m365_nxt = 18'(yoe_r[11]) * 18'(DAYS_YR);
    adj_nxt  = 7'(yoe_r[11] >> 2) - 7'(c100);

    // Stage 13: day of year, March based.
    doy_nxt  = 9'(doe_r[12] - m365_r - 18'(adj_r));

    // Stage 14: month found by comparing against each month start.
    mp_nxt   = '0;
    for (int k = 1; k < MONTHS; k++) begin
      if (doy_r[13] >= month_start(4'(k))) begin
        mp_nxt = mp_nxt + 4'd1;
      end
    end

    // Stage 15: civil month, day and year; January and February move on.
    month_nxt = (mp_r < 4'd10) ? mp_r + 4'd3 : mp_r - 4'd9;
    day_nxt   = 5'(doy_r[14] - month_start(mp_r) + 9'd1);
    year_nxt  = (era5_r[NUM_STG-1] ? YEAR_ERA5 : YEAR_ERA4)
              + 12'(yoe_r[NUM_STG-1]) + 12'(mp_r >= 4'd10);
  end

  // Valid bits and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[NUM_STG-1:1], in_take};
    end
  end

  // Payload registers of every stage.
  always_ff @(posedge clk) begin
    t_r[1]    <= in_epoch_seconds;
    t_r[2]    <= t_r[1];
    zero_r[1] <= in_epoch_seconds == '0;
    pd_r      <= pd_nxt;
    q_r       <= q_nxt;
    pq_r      <= pq_nxt;
    days_r    <= days_nxt;
    sod_r[3]  <= sod_nxt;
    era5_r[4] <= era5_nxt;
    doe_r[4]  <= doe_nxt;
    pm_r      <= pm_nxt;
    pa_r      <= pa_nxt;
    cent_r[5] <= cent_nxt;
    last_r[5] <= last_nxt;
    qm_r      <= qm_nxt;
    pqm_r     <= pqm_nxt;
    a0_r      <= a0_nxt;
    pqa_r     <= pqa_nxt;
    mn_r[6]   <= mn_nxt;
    ss_r[6]   <= ss_nxt;
    a_r       <= a_nxt;
    ph_r      <= ph_nxt;
    n_r[8]    <= n_nxt;
    qh_r      <= qh_nxt;
    pqh_r     <= pqh_nxt;
    py_r      <= py_nxt;
    hh_r[9]   <= hh_nxt;
    mi_r[9]   <= mi_nxt;
    y0_r      <= y0_nxt;
    pqy_r     <= pqy_nxt;
    yoe_r[11] <= yoe_nxt;
    m365_r    <= m365_nxt;
    adj_r     <= adj_nxt;
    doy_r[13] <= doy_nxt;
    mp_r      <= mp_nxt;
    year_r    <= year_nxt;
    month_r   <= month_nxt;
    day_r     <= day_nxt;
    hour_r    <= hh_r[NUM_STG-1];
    minute_r  <= mi_r[NUM_STG-1];
    second_r  <= ss_r[NUM_STG-1];
    unk_r     <= zero_r[NUM_STG-1];

    // Values that ride along until their stage needs them.
    for (int k = 2; k <= NUM_STG-1; k++) zero_r[k] <= zero_r[k-1];
    for (int k = 4; k <= 5; k++)         sod_r[k]  <= sod_r[k-1];
    for (int k = 5; k <= NUM_STG-1; k++) era5_r[k] <= era5_r[k-1];
    for (int k = 5; k <= 12; k++)        doe_r[k]  <= doe_r[k-1];
    for (int k = 6; k <= 7; k++)         cent_r[k] <= cent_r[k-1];
    for (int k = 6; k <= 7; k++)         last_r[k] <= last_r[k-1];
    for (int k = 7; k <= 8; k++)         mn_r[k]   <= mn_r[k-1];
    for (int k = 7; k <= NUM_STG-1; k++) ss_r[k]   <= ss_r[k-1];
    for (int k = 9; k <= 10; k++)        n_r[k]    <= n_r[k-1];
    for (int k = 10; k <= NUM_STG-1; k++) hh_r[k]  <= hh_r[k-1];
    for (int k = 10; k <= NUM_STG-1; k++) mi_r[k]  <= mi_r[k-1];
    for (int k = 12; k <= NUM_STG-1; k++) yoe_r[k] <= yoe_r[k-1];
    doy_r[14] <= doy_r[13];
  end

  // Outputs.
  assign busy             = busy_r;
  assign out_valid        = vld_r[NUM_STG];
  assign out_year         = year_r;
  assign out_month        = month_r;
  assign out_day          = day_r;
  assign out_hour         = hour_r;
  assign out_minute       = minute_r;
  assign out_second       = second_r;
  assign out_unknown_time = unk_r;

  // The second of day leaves the day divide below one full day.
  `ASSERT_IMPLY(a_sod_range, clk, rst_n, vld_r[3],
                sod_r[3] < 17'(SECS_PER_DAY), "second of day out of range")
  // The month search never runs past the last March-based month.
  `ASSERT_IMPLY(a_mp_range, clk, rst_n, vld_r[14], mp_r < 4'(MONTHS),
                "month index out of range")
  // The unknown-time sentinel decodes to the epoch itself.
  `ASSERT_IMPLY(a_zero_epoch, clk, rst_n, out_valid && out_unknown_time,
                out_year == 12'd1970 && out_month == 4'd1 && out_day == 5'd1
                && out_hour == 5'd0 && out_minute == 6'd0 && out_second == 6'd0,
                "zero input did not decode to the epoch")
  // A request in the last internal stage always reaches the outputs.
  `ASSERT_NEXT(a_vld_out, clk, rst_n, vld_r[NUM_STG-1], out_valid,
               "request lost before the outputs")

endmodule

// ===== test/unix_time_to_calendar_unit_tb.sv =====
// Testbench for unix_time_to_calendar_unit: drives epoch second counts and checks
// every calendar result against a behavioral civil-from-days decoder.
// Depends on utcal_pkg and the RTL of unix_time_to_calendar_unit.
module unix_time_to_calendar_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utcal_pkg::*;

  // Expected calendar fields for one request.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               unknown_time;
  } civil_stamp_t;

  localparam int RANDOM_REQUESTS = 850;
  localparam int STALL_LIMIT     = 1000;
  localparam int DRAIN_CYCLES    = NUM_STG + 5;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [EPOCH_W-1:0]  in_epoch_seconds = '0;
  logic                out_valid;
  logic [YEAR_W-1:0]   out_year;
  logic [MONTH_W-1:0]  out_month;
  logic [DAY_W-1:0]    out_day;
  logic [HOUR_W-1:0]   out_hour;
  logic [MIN_W-1:0]    out_minute;
  logic [SEC_W-1:0]    out_second;
  logic                out_unknown_time;

  logic [EPOCH_W-1:0]  pending_epochs[$];
  logic [EPOCH_W-1:0]  issued_epochs[$];
  civil_stamp_t        expected_stamps[$];
  int                  request_total = 0;
  int                  accepted_count = 0;
  int                  driven_count = 0;
  int                  mismatch_count = 0;
  int                  stall_cycles = 0;

  unix_time_to_calendar_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_unknown_time (out_unknown_time)
  );

  // Clock: 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decode seconds since 1970 into a civil date with March-based 400-year eras.
  function automatic civil_stamp_t civil_from_epoch(input logic [EPOCH_W-1:0] epoch);
    int unsigned  sod, days, z, era, doe, yoe, yr, doy, mp, dd, mm;
    civil_stamp_t stamp;
    sod  = epoch % 86400;
    days = epoch / 86400;
    z    = days + 719468;
    era  = z / 146097;
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    yr   = yoe + era * 400;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    dd   = doy - (153 * mp + 2) / 5 + 1;
    mm   = (mp < 10) ? mp + 3 : mp - 9;
    // January and February belong to the following civil year.
    if (mm <= 2) begin
      yr = yr + 1;
    end
    stamp.year         = yr[YEAR_W-1:0];
    stamp.month        = mm[MONTH_W-1:0];
    stamp.day          = dd[DAY_W-1:0];
    stamp.hour         = HOUR_W'(sod / 3600);
    stamp.minute       = MIN_W'((sod % 3600) / 60);
    stamp.second       = SEC_W'(sod % 60);
    stamp.unknown_time = (epoch == '0);
    return stamp;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string field, input logic [EPOCH_W-1:0] epoch,
                                 input int unsigned got, input int unsigned want);
    $display("MISMATCH %s for epoch %0d: got %0d, expected %0d", field, epoch, got, want);
    mismatch_count++;
  endtask

  // Driver: presents queued requests, idling at random outside a gap-free stretch.
  always @(posedge clk) begin : drive
    bit hold_off;
    if (!rst_n) begin
      start <= 1'b0;
      in_epoch_seconds <= '0;
    end else if (!start || !busy) begin
      hold_off = ($urandom_range(0, 99) < 10) && !(driven_count >= 300 && driven_count < 500);
      if (pending_epochs.size() > 0 && !hold_off) begin
        start <= 1'b1;
        in_epoch_seconds <= pending_epochs.pop_front();
        driven_count++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result first, then records the request taken at this edge.
  always @(posedge clk) begin : observe
    civil_stamp_t want;
    logic [EPOCH_W-1:0] epoch;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_stamps.size() == 0) begin
          // A result with no request outstanding counts as one mismatch.
          report_mismatch("unexpected result", '0, 1, 0);
        end else begin
          want  = expected_stamps.pop_front();
          epoch = issued_epochs.pop_front();
          if (out_year !== want.year)
            report_mismatch("year", epoch, out_year, want.year);
          if (out_month !== want.month)
            report_mismatch("month", epoch, out_month, want.month);
          if (out_day !== want.day)
            report_mismatch("day", epoch, out_day, want.day);
          if (out_hour !== want.hour)
            report_mismatch("hour", epoch, out_hour, want.hour);
          if (out_minute !== want.minute)
            report_mismatch("minute", epoch, out_minute, want.minute);
          if (out_second !== want.second)
            report_mismatch("second", epoch, out_second, want.second);
          if (out_unknown_time !== want.unknown_time)
            report_mismatch("unknown_time", epoch, out_unknown_time, want.unknown_time);
        end
      end
      if (start && !busy) begin
        expected_stamps.push_back(civil_from_epoch(in_epoch_seconds));
        issued_epochs.push_back(in_epoch_seconds);
        accepted_count++;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout waiting for a request or result");
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    logic [EPOCH_W-1:0] directed[] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
      32'd86399, 32'd86400,
      32'd68169599, 32'd68169600,        // 1972 leap day boundary
      32'd951782399, 32'd951782400,      // 2000 leap day, era start year
      32'd951868800,                     // 2000-03-01, start of the era
      32'd4107542399, 32'd4107542400,    // end of February 2100, not a leap year
      32'd946684799, 32'd946684800,      // turn of the year 2000
      32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
    };
    int unsigned days;
    int unsigned pick;
    foreach (directed[i]) begin
      pending_epochs.push_back(directed[i]);
    end
    // Random requests: full range, near day edges, near zero and near the top.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pending_epochs.push_back($urandom);
      end else if (pick < 85) begin
        days = $urandom_range(0, 49709);
        if ($urandom_range(0, 1))
          pending_epochs.push_back(days * 86400 + $urandom_range(0, 2));
        else
          pending_epochs.push_back(days * 86400 + 86400 - $urandom_range(1, 3));
      end else if (pick < 93) begin
        pending_epochs.push_back($urandom_range(0, 200));
      end else begin
        pending_epochs.push_back(32'hFFFF_FFFF - $urandom_range(0, 300000));
      end
    end
    request_total = pending_epochs.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < request_total) @(posedge clk);
    while (expected_stamps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/utcal_pkg.sv
rtl/unix_time_to_calendar_unit.sv
test/unix_time_to_calendar_unit_tb.sv
